// ----- design/nfcv_pkg.sv -----
// shared types, constants and crc function for the node frame crc verifier
package nfcv_pkg;

    localparam int unsigned DATA_W = 8;
    localparam int unsigned POS_W = 9;
    localparam int unsigned CRC_W = 16;
    localparam int unsigned ADDR_W = 2;
    localparam int unsigned PDATA_W = 32;

    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY_REFL = 16'hA001;
    localparam logic [DATA_W-1:0] HEADER_RESET = 8'hAA;
    localparam logic [POS_W-1:0] FIXED_PART = 9'h009;

    localparam logic [ADDR_W-1:0] REG_EXPECTED_HEADER = 2'd0;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_BAD_HEADER   = 2'd1,
        ST_CRC_MISMATCH = 2'd2
    } status_t;

    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic              frame_start;
    } in_word_t;

    typedef struct packed {
        status_t           status;
        logic [7:0]        opcode;
        logic [15:0]       source_address;
        logic [7:0]        payload_length;
        logic [CRC_W-1:0]  computed_crc;
    } result_t;

    typedef struct packed {
        logic consume;
        logic result_fire;
        logic in_frame;
    } core_stat_t;

    // crc-16/modbus update by one byte, lsb first
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                  input logic [DATA_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {{(CRC_W-DATA_W){1'b0}}, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY_REFL;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// ----- design/node_frame_crc_verifier_top.sv -----
// top level of the node frame crc verifier
// words pass from the input register through the combinational core into the result register
// throughput: one word per cycle while the output is not stalled, with an unrolled crc byte update
// a frame's result is shown from the edge at which its last word leaves the input register
// a result held by a stalled output stalls the input until it is taken
// reset: rst_n asynchronous active low, clears frame state, header resets to 0xaa
module node_frame_crc_verifier_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nfcv_pkg::ADDR_W-1:0]   paddr,
    input  logic [nfcv_pkg::PDATA_W-1:0]  pwdata,
    output logic [nfcv_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    data_byte,
    input  logic                          frame_start,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    status,
    output logic [7:0]                    opcode,
    output logic [15:0]                   source_address,
    output logic [7:0]                    payload_length,
    output logic [15:0]                   computed_crc
);
    import nfcv_pkg::*;

    logic [DATA_W-1:0] expected_header;
    in_word_t          in_word;
    in_word_t          word;
    logic              word_valid;
    logic              out_ready;
    logic              res_valid;
    result_t           res;
    result_t           out_res;
    core_stat_t        core_stat;

    assign in_word.data_byte = data_byte;
    assign in_word.frame_start = frame_start;

    nfcv_cfg u_cfg (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .expected_header (expected_header)
    );

    nfcv_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_word    (in_word),
        .consume    (core_stat.consume),
        .word_valid (word_valid),
        .word       (word)
    );

    nfcv_core u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .word_valid      (word_valid),
        .word            (word),
        .out_ready       (out_ready),
        .expected_header (expected_header),
        .res_valid       (res_valid),
        .res             (res),
        .stat            (core_stat)
    );

    nfcv_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign status         = out_res.status;
    assign opcode         = out_res.opcode;
    assign source_address = out_res.source_address;
    assign payload_length = out_res.payload_length;
    assign computed_crc   = out_res.computed_crc;

    // a result is only made from a word taken out of the input register
    a_result_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        core_stat.result_fire |-> (word_valid && core_stat.consume))
        else $error("result without a consumed word");

    // the frame closes after its result
    a_frame_closes: assert property (@(posedge clk) disable iff (!rst_n)
        core_stat.result_fire |=> !core_stat.in_frame)
        else $error("frame still open after result");

    // a new result never overwrites one still held by a stalled output
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> !res_valid)
        else $error("result register overwritten while stalled");

    // reported status is always a defined code
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK || status == ST_BAD_HEADER
                       || status == ST_CRC_MISMATCH))
        else $error("undefined status code");

endmodule

// ----- design/nfcv_cfg.sv -----
// apb configuration register holding the expected header byte
module nfcv_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nfcv_pkg::ADDR_W-1:0]   paddr,
    input  logic [nfcv_pkg::PDATA_W-1:0]  pwdata,
    output logic [nfcv_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output logic [nfcv_pkg::DATA_W-1:0]   expected_header
);
    import nfcv_pkg::*;

    logic [DATA_W-1:0] header_reg;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en = psel & penable & pwrite & (paddr == REG_EXPECTED_HEADER);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            header_reg <= HEADER_RESET;
        else if (wr_en)
            header_reg <= pwdata[DATA_W-1:0];
    end

    always_comb
    begin
        if (paddr == REG_EXPECTED_HEADER)
            prdata = {{(PDATA_W-DATA_W){1'b0}}, header_reg};
        else
            prdata = '0;
    end

    assign expected_header = header_reg;

endmodule

// ----- design/nfcv_in_reg.sv -----
// input register stage holding one accepted word
module nfcv_in_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  nfcv_pkg::in_word_t  in_word,
    input  logic                consume,
    output logic                word_valid,
    output nfcv_pkg::in_word_t  word
);
    import nfcv_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_word_t word_reg;
    logic     accept;

    assign in_stall = valid_reg & ~consume;
    assign accept = in_valid & ~in_stall;

    always_comb
    begin
        if (accept)
            valid_next = 1'b1;
        else if (consume)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            word_reg <= in_word;
    end

    assign word_valid = valid_reg;
    assign word = word_reg;

endmodule

// ----- design/nfcv_core.sv -----
// frame tracking, crc update and frame check for one word per cycle while the output is ready
module nfcv_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         word_valid,
    input  nfcv_pkg::in_word_t           word,
    input  logic                         out_ready,
    input  logic [nfcv_pkg::DATA_W-1:0]  expected_header,
    output logic                         res_valid,
    output nfcv_pkg::result_t            res,
    output nfcv_pkg::core_stat_t         stat
);
    import nfcv_pkg::*;

    localparam logic [POS_W-1:0] POS_HEADER = 9'd0;
    localparam logic [POS_W-1:0] POS_OPCODE = 9'd1;
    localparam logic [POS_W-1:0] POS_ADDR_HI = 9'd2;
    localparam logic [POS_W-1:0] POS_ADDR_LO = 9'd3;
    localparam logic [POS_W-1:0] POS_LENGTH = 9'd6;
    localparam logic [POS_W-1:0] POS_CRC_HI = 9'd7;
    localparam logic [POS_W-1:0] POS_CRC_LO = 9'd8;

    logic [POS_W-1:0]  pos_reg,    pos_next;
    logic              frame_reg,  frame_next;
    logic [7:0]        len_reg,    len_next;
    logic [CRC_W-1:0]  crc_reg,    crc_next;
    logic [CRC_W-1:0]  rcv_reg,    rcv_next;
    logic              hdr_ok_reg, hdr_ok_next;
    logic [7:0]        op_reg,     op_next;
    logic [15:0]       addr_reg,   addr_next;

    logic              consume;
    logic              active;
    logic [POS_W-1:0]  pos_cur;
    logic [7:0]        len_cur;
    logic [CRC_W-1:0]  crc_cur;
    logic [CRC_W-1:0]  rcv_cur;
    logic              hdr_ok_cur;
    logic [7:0]        op_cur;
    logic [15:0]       addr_cur;
    logic [DATA_W-1:0] feed;
    logic [CRC_W-1:0]  crc_upd;
    logic              last;

    assign consume = word_valid & out_ready;
    assign active = word.frame_start | frame_reg;

    always_comb
    begin
        if (word.frame_start)
        begin
            pos_cur    = '0;
            len_cur    = '0;
            crc_cur    = CRC_INIT;
            rcv_cur    = '0;
            hdr_ok_cur = 1'b0;
            op_cur     = '0;
            addr_cur   = '0;
        end
        else
        begin
            pos_cur    = pos_reg;
            len_cur    = len_reg;
            crc_cur    = crc_reg;
            rcv_cur    = rcv_reg;
            hdr_ok_cur = hdr_ok_reg;
            op_cur     = op_reg;
            addr_cur   = addr_reg;
        end

        feed        = word.data_byte;
        len_next    = len_cur;
        rcv_next    = rcv_cur;
        hdr_ok_next = hdr_ok_cur;
        op_next     = op_cur;
        addr_next   = addr_cur;

        case (pos_cur)
            POS_HEADER:  hdr_ok_next = (word.data_byte == expected_header);
            POS_OPCODE:  op_next = word.data_byte;
            POS_ADDR_HI: addr_next = {word.data_byte, addr_cur[7:0]};
            POS_ADDR_LO: addr_next = {addr_cur[15:8], word.data_byte};
            POS_LENGTH:  len_next = word.data_byte;
            POS_CRC_HI:
            begin
                rcv_next = {word.data_byte, rcv_cur[7:0]};
                feed = '0;
            end
            POS_CRC_LO:
            begin
                rcv_next = {rcv_cur[15:8], word.data_byte};
                feed = '0;
            end
            default: ;
        endcase

        crc_upd = crc_byte(crc_cur, feed);
        last = (pos_cur >= POS_CRC_LO)
               && (pos_cur == (FIXED_PART - 9'd1 + {1'b0, len_next}));
    end

    always_comb
    begin
        pos_next   = pos_reg;
        frame_next = frame_reg;
        crc_next   = crc_reg;
        if (consume && active)
        begin
            crc_next = crc_upd;
            if (last)
            begin
                frame_next = 1'b0;
                pos_next   = '0;
            end
            else
            begin
                frame_next = 1'b1;
                pos_next   = pos_cur + 9'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            frame_reg  <= 1'b0;
            len_reg    <= '0;
            crc_reg    <= CRC_INIT;
            rcv_reg    <= '0;
            hdr_ok_reg <= 1'b0;
            op_reg     <= '0;
            addr_reg   <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            frame_reg <= frame_next;
            crc_reg   <= crc_next;
            if (consume && active)
            begin
                len_reg    <= len_next;
                rcv_reg    <= rcv_next;
                hdr_ok_reg <= hdr_ok_next;
                op_reg     <= op_next;
                addr_reg   <= addr_next;
            end
        end
    end

    always_comb
    begin
        res_valid = consume & active & last;
        if (!hdr_ok_next)
            res.status = ST_BAD_HEADER;
        else if (rcv_next != crc_upd)
            res.status = ST_CRC_MISMATCH;
        else
            res.status = ST_OK;
        res.opcode         = op_next;
        res.source_address = addr_next;
        res.payload_length = len_next;
        res.computed_crc   = crc_upd;
    end

    assign stat.consume     = consume;
    assign stat.result_fire = res_valid;
    assign stat.in_frame    = frame_reg;

endmodule

// ----- design/nfcv_out_reg.sv -----
// result register toward the output channel
module nfcv_out_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               res_valid,
    input  nfcv_pkg::result_t  res,
    output logic               out_ready,
    output logic               out_valid,
    input  logic               out_stall,
    output nfcv_pkg::result_t  out_res
);
    import nfcv_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign out_ready = ~valid_reg | ~out_stall;

    always_comb
    begin
        if (res_valid)
            valid_next = 1'b1;
        else if (!out_stall)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
            res_reg <= res;
    end

    assign out_valid = valid_reg;
    assign out_res = res_reg;

endmodule

// ----- tb/frame_result_checker.sv -----
// crc helper package and the checker that predicts and compares frame results
package nfcv_tb_pkg;

    function automatic logic [15:0] modbus_crc_update(input logic [15:0] crc_now,
                                                      input logic [7:0] octet);
        logic [15:0] acc;
        logic        fb;
        acc = crc_now;
        for (int k = 0; k < 8; k++)
        begin
            fb = acc[0] ^ octet[k];
            acc = acc >> 1;
            if (fb)
                acc = acc ^ nfcv_pkg::CRC_POLY_REFL;
        end
        return acc;
    endfunction

endpackage

module frame_result_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nfcv_pkg::ADDR_W-1:0]   paddr,
    input  logic [nfcv_pkg::PDATA_W-1:0]  pwdata,
    input  logic [nfcv_pkg::PDATA_W-1:0]  prdata,
    input  logic                          pready,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [7:0]                    data_byte,
    input  logic                          frame_start,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [1:0]                    status,
    input  logic [7:0]                    opcode,
    input  logic [15:0]                   source_address,
    input  logic [7:0]                    payload_length,
    input  logic [15:0]                   computed_crc,
    output int                            failures,
    output int                            frames_due
);

    import nfcv_pkg::*;
    import nfcv_tb_pkg::*;

    localparam int OFS_HEADER  = 0;
    localparam int OFS_OPCODE  = 1;
    localparam int OFS_ADDR_HI = 2;
    localparam int OFS_ADDR_LO = 3;
    localparam int OFS_LENGTH  = 6;
    localparam int OFS_CRC_HI  = 7;
    localparam int OFS_CRC_LO  = 8;

    result_t          frame_results_due[$];
    result_t          oldest;
    result_t          fresh;
    int               mismatch_total;

    logic [7:0]       header_setting;
    logic [8:0]       offset;
    logic             frame_open;
    logic [7:0]       length_seen;
    logic [15:0]      running_crc;
    logic [15:0]      crc_on_wire;
    logic             header_match;
    logic [7:0]       opcode_seen;
    logic [15:0]      address_seen;
    logic [7:0]       crc_feed;

    task automatic compare_field(input string field, input int want, input int got);
        if (want != got)
        begin
            $error("%s expected 0x%0h actual 0x%0h", field, want, got);
            mismatch_total++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_results_due.delete();
            mismatch_total = 0;
            header_setting = HEADER_RESET;
            offset = '0;
            frame_open = 1'b0;
            length_seen = '0;
            running_crc = CRC_INIT;
            crc_on_wire = '0;
            header_match = 1'b0;
            opcode_seen = '0;
            address_seen = '0;
            failures <= 0;
            frames_due <= 0;
        end
        else
        begin
            if (psel && penable && pready && paddr == REG_EXPECTED_HEADER)
            begin
                if (pwrite)
                    header_setting = pwdata[7:0];
                else
                    compare_field("expected_header readback", header_setting, prdata[7:0]);
            end

            if (out_valid && !out_stall)
            begin
                if (frame_results_due.size() == 0)
                begin
                    $error("result word with no frame result pending");
                    mismatch_total++;
                end
                else
                begin
                    oldest = frame_results_due.pop_front();
                    compare_field("status", oldest.status, status);
                    compare_field("opcode", oldest.opcode, opcode);
                    compare_field("source_address", oldest.source_address, source_address);
                    compare_field("payload_length", oldest.payload_length, payload_length);
                    compare_field("computed_crc", oldest.computed_crc, computed_crc);
                end
            end

            if (in_valid && !in_stall)
            begin
                // a start word abandons any open frame
                if (frame_start)
                begin
                    offset = '0;
                    frame_open = 1'b1;
                    length_seen = '0;
                    running_crc = CRC_INIT;
                    crc_on_wire = '0;
                    header_match = 1'b0;
                    opcode_seen = '0;
                    address_seen = '0;
                end
                if (frame_open)
                begin
                    crc_feed = data_byte;
                    case (offset)
                        OFS_HEADER:  header_match = (data_byte == header_setting);
                        OFS_OPCODE:  opcode_seen = data_byte;
                        OFS_ADDR_HI: address_seen[15:8] = data_byte;
                        OFS_ADDR_LO: address_seen[7:0] = data_byte;
                        OFS_LENGTH:  length_seen = data_byte;
                        OFS_CRC_HI:
                        begin
                            crc_on_wire[15:8] = data_byte;
                            crc_feed = '0;
                        end
                        OFS_CRC_LO:
                        begin
                            crc_on_wire[7:0] = data_byte;
                            crc_feed = '0;
                        end
                        default: ;
                    endcase
                    running_crc = modbus_crc_update(running_crc, crc_feed);

                    if (offset >= OFS_CRC_LO && offset == 9'(OFS_CRC_LO) + 9'(length_seen))
                    begin
                        if (!header_match)
                            fresh.status = ST_BAD_HEADER;
                        else if (crc_on_wire != running_crc)
                            fresh.status = ST_CRC_MISMATCH;
                        else
                            fresh.status = ST_OK;
                        fresh.opcode = opcode_seen;
                        fresh.source_address = address_seen;
                        fresh.payload_length = length_seen;
                        fresh.computed_crc = running_crc;
                        frame_results_due.push_back(fresh);
                        frame_open = 1'b0;
                        offset = '0;
                    end
                    else
                        offset = offset + 9'd1;
                end
            end

            failures <= mismatch_total;
            frames_due <= frame_results_due.size();
        end
    end

endmodule

// ----- tb/node_frame_crc_verifier_top_test.sv -----
// stimulus, clock, reset and verdict for the node frame crc verifier
module node_frame_crc_verifier_top_test;

    import nfcv_pkg::*;
    import nfcv_tb_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 300;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_W-1:0]     paddr;
    logic [PDATA_W-1:0]    pwdata;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;
    logic                  in_valid;
    logic                  in_stall;
    logic [7:0]            data_byte;
    logic                  frame_start;
    logic                  out_valid;
    logic                  out_stall;
    logic [1:0]            status;
    logic [7:0]            opcode;
    logic [15:0]           source_address;
    logic [7:0]            payload_length;
    logic [15:0]           computed_crc;

    int                    failures;
    int                    frames_due;
    int                    cycle_count;
    bit                    send_gaps;
    bit                    stall_gaps;
    int                    hold_requests;
    int                    holds_served;
    logic [7:0]            header_now;

    node_frame_crc_verifier_top u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .frame_start    (frame_start),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .opcode         (opcode),
        .source_address (source_address),
        .payload_length (payload_length),
        .computed_crc   (computed_crc)
    );

    frame_result_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .frame_start    (frame_start),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .opcode         (opcode),
        .source_address (source_address),
        .payload_length (payload_length),
        .computed_crc   (computed_crc),
        .failures       (failures),
        .frames_due     (frames_due)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("node_frame_crc_verifier_top verification failed");
            $finish;
        end
    end

    // result side: random stall bursts, or a long hold on request
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != holds_served)
            begin
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall = 1'b0;
                holds_served++;
            end
            else if (stall_gaps && $urandom_range(0, 5) == 0)
            begin
                out_stall = 1'b1;
                repeat ($urandom_range(1, 12)) @(negedge clk);
                out_stall = 1'b0;
            end
            else
                out_stall = 1'b0;
        end
    end

    task automatic send_word(input logic [7:0] octet, input logic first);
        @(negedge clk);
        if (send_gaps && $urandom_range(0, 4) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        in_valid = 1'b1;
        data_byte = octet;
        frame_start = first;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic idle_input();
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic wait_results_done();
        idle_input();
        while (frames_due != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // cut >= 0 stops the frame after that many words, leaving it unfinished
    task automatic send_frame(input logic [7:0] hdr, input logic [7:0] op,
                              input logic [15:0] addr, input logic [7:0] len,
                              input bit crc_good, input int cut);
        logic [7:0]  octets[$];
        logic [15:0] crc;
        logic [15:0] flip;
        int          count;
        octets = {hdr, op, addr[15:8], addr[7:0], 8'($urandom), 8'($urandom), len,
                  8'h00, 8'h00};
        repeat (len) octets.push_back(8'($urandom));
        crc = CRC_INIT;
        foreach (octets[i])
            crc = modbus_crc_update(crc, octets[i]);
        if (!crc_good)
        begin
            flip = 16'(1) << $urandom_range(0, 15);
            crc = crc ^ flip;
        end
        octets[7] = crc[15:8];
        octets[8] = crc[7:0];
        count = (cut >= 0) ? cut : octets.size();
        for (int i = 0; i < count; i++)
            send_word(octets[i], i == 0);
    endtask

    task automatic write_header(input logic [7:0] hdr);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = REG_EXPECTED_HEADER;
        pwdata = {24'($urandom), hdr};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        // read it back
        @(negedge clk);
        penable = 1'b0;
        pwrite = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        header_now = hdr;
    endtask

    task automatic run_random(input int budget, input bit idle_ok);
        int         sent;
        int         pick;
        int         cut;
        logic [7:0] len;
        logic [7:0] hdr;
        sent = 0;
        while (sent < budget)
        begin
            send_gaps = idle_ok && $urandom_range(0, 3) != 0;
            stall_gaps = idle_ok && $urandom_range(0, 3) != 0;
            pick = $urandom_range(0, 99);
            if (pick < 85)
                len = 8'($urandom_range(0, 8));
            else if (pick < 97)
                len = 8'($urandom_range(9, 40));
            else
                len = 8'($urandom_range(200, 255));
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                repeat ($urandom_range(1, 4))
                    send_word(8'($urandom), 1'b0);
            end
            else if (pick < 18)
            begin
                cut = $urandom_range(1, 8 + int'(len));
                send_frame(header_now, 8'($urandom), 16'($urandom), len, 1'b1, cut);
                sent += cut;
            end
            else
            begin
                hdr = (pick < 28) ? 8'($urandom) : header_now;
                send_frame(hdr, 8'($urandom), 16'($urandom), len,
                           $urandom_range(0, 3) != 0, -1);
                sent += 9 + int'(len);
            end
        end
        // close cleanly so the block is idle afterwards
        send_frame(header_now, 8'($urandom), 16'($urandom), 8'd0, 1'b1, -1);
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        data_byte = '0;
        frame_start = 1'b0;
        cycle_count = 0;
        send_gaps = 1'b0;
        stall_gaps = 1'b0;
        hold_requests = 0;
        holds_served = 0;
        header_now = HEADER_RESET;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed frames against the reset header
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b0);
        send_frame(8'hAA, 8'hFF, 16'hFFFF, 8'd0, 1'b1, -1);
        send_frame(8'hAA, 8'h00, 16'h0000, 8'd1, 1'b0, -1);
        send_frame(8'h55, 8'h3C, 16'h8001, 8'd2, 1'b1, -1);
        send_frame(8'h00, 8'hC3, 16'h7FFE, 8'd0, 1'b0, -1);
        send_frame(8'hAA, 8'h5A, 16'h1234, 8'd3, 1'b1, 5);
        send_frame(8'hAA, 8'hA5, 16'hEDCB, 8'd1, 1'b1, -1);
        send_word(8'h81, 1'b0);
        send_frame(8'hAA, 8'h11, 16'hF00F, 8'd255, 1'b1, -1);
        wait_results_done();

        write_header(8'h00);
        run_random(250, 1'b1);
        wait_results_done();

        write_header(8'hFF);
        // fill the block while results are held back
        send_gaps = 1'b0;
        stall_gaps = 1'b0;
        hold_requests++;
        repeat (10)
            send_frame(header_now, 8'($urandom), 16'($urandom), 8'd0, 1'b1, -1);
        run_random(125, 1'b1);
        wait_results_done();
        run_random(125, 1'b1);
        wait_results_done();

        write_header(8'($urandom));
        run_random(250, 1'b1);
        wait_results_done();

        write_header(8'hAA);
        run_random(250, 1'b0);
        wait_results_done();
        repeat (8) @(posedge clk);

        if (failures == 0)
            $display("node_frame_crc_verifier_top verification clean");
        else
            $display("node_frame_crc_verifier_top verification failed");
        $finish;
    end

endmodule
